### hdl/cpa_pkg.sv
// Shared types, codes and state encoding for the compacting pool allocator.
`default_nettype none

package cpa_pkg;

  // Field widths of the request and result items
  localparam int FUNC_W   = 2;
  localparam int SIZE_W   = 11;
  localparam int ADDR_W   = 10;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] write_byte;
  } cpa_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   block_start;
    logic [BYTE_W-1:0]   read_byte;
  } cpa_out_t;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic     valid;
    cpa_out_t data;
  } cpa_res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_MATCH,
    ST_NEXT,
    ST_ENTRY,
    ST_MOVE,
    ST_READ,
    ST_DONE
  } cpa_state_t;

endpackage

`default_nettype wire

### hdl/cpa_ram.sv
// Simple dual-port synchronous RAM with registered read.
`default_nettype none

module cpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/cpa_ctrl.sv
// Sequencer for the allocator: block table, byte pool, search and compaction.
`default_nettype none

module cpa_ctrl #(
  parameter int POOL_BYTES   = 1024,
  parameter int HEADER_BYTES = 8,
  parameter int MAX_ENTRIES  = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire cpa_pkg::cpa_in_t in_data,
  input  wire logic             out_free,
  output cpa_pkg::cpa_res_t     res
);

  import cpa_pkg::*;

  localparam int PW   = $clog2(POOL_BYTES + 1);
  localparam int AW   = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
  localparam int CW   = ((PW > SIZE_W) ? PW : SIZE_W) + 2;
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int TW   = 2 * PW;

  cpa_state_t state_r, state_nxt;

  logic [CNTW-1:0] count_r, count_nxt;
  logic [PW-1:0]   left_r, left_nxt;
  logic [PW-1:0]   used_r, used_nxt;
  logic [CNTW-1:0] idx_r, idx_nxt;
  logic [PW-1:0]   gap_r, gap_nxt;
  logic [PW-1:0]   src_r, src_nxt;
  logic [PW-1:0]   cnt_r, cnt_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   waddr_r, waddr_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  cpa_out_t        res_r, res_nxt;

  // Memory ports
  logic            pool_we, pool_re;
  logic [AW-1:0]   pool_waddr, pool_raddr;
  logic [BYTE_W-1:0] pool_wdata, pool_rdata;
  logic            tab_we, tab_re;
  logic [IW-1:0]   tab_waddr, tab_raddr;
  logic [TW-1:0]   tab_wdata, tab_rdata;

  // Working values at a common width
  logic [CW-1:0]   in_size_w, in_addr_w, need_w, left_w, used_w, fit_w, off_w;
  logic [CW-1:0]   tab_off_w, tab_size_w, gap_w, mv_end_w, rd_w, wr_w, new_off_w;
  logic [PW-1:0]   tab_off, tab_size;
  logic [CNTW-1:0] prev_idx;
  logic            in_range;

  cpa_ram #(.WIDTH(BYTE_W), .DEPTH(POOL_BYTES)) u_pool (
    .clk  (clk),
    .we   (pool_we),
    .waddr(pool_waddr),
    .wdata(pool_wdata),
    .re   (pool_re),
    .raddr(pool_raddr),
    .rdata(pool_rdata)
  );

  cpa_ram #(.WIDTH(TW), .DEPTH(MAX_ENTRIES)) u_table (
    .clk  (clk),
    .we   (tab_we),
    .waddr(tab_waddr),
    .wdata(tab_wdata),
    .re   (tab_re),
    .raddr(tab_raddr),
    .rdata(tab_rdata)
  );

  assign tab_off    = tab_rdata[TW-1:PW];
  assign tab_size   = tab_rdata[PW-1:0];
  assign in_size_w  = CW'(in_data.alloc_size);
  assign in_addr_w  = CW'(in_data.address);
  assign need_w     = in_size_w + CW'(HEADER_BYTES);
  assign left_w     = CW'(left_r);
  assign used_w     = CW'(used_r);
  assign fit_w      = used_w + in_size_w;
  assign off_w      = CW'(POOL_BYTES) - used_w - in_size_w;
  assign in_range   = in_addr_w < CW'(POOL_BYTES);
  assign tab_off_w  = CW'(tab_off);
  assign tab_size_w = CW'(tab_size);
  assign gap_w      = CW'(gap_r);
  assign new_off_w  = tab_off_w + gap_w;
  assign mv_end_w   = new_off_w + tab_size_w;
  assign rd_w       = CW'(src_r) + CW'(cnt_r) - CW'(1);
  assign wr_w       = rd_w + gap_w;
  assign prev_idx   = idx_r - CNTW'(1);

  // Hold state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      count_r <= '0;
      left_r  <= PW'(POOL_BYTES);
      used_r  <= '0;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      used_r  <= used_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Hold working payload
  always_ff @(posedge clk) begin
    gap_r   <= gap_nxt;
    src_r   <= src_nxt;
    cnt_r   <= cnt_nxt;
    waddr_r <= waddr_nxt;
    addr_r  <= addr_nxt;
    rd_ok_r <= rd_ok_nxt;
    res_r   <= res_nxt;
  end

  // Next state, memory accesses and result
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    left_nxt   = left_r;
    used_nxt   = used_r;
    idx_nxt    = idx_r;
    gap_nxt    = gap_r;
    src_nxt    = src_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    waddr_nxt  = waddr_r;
    clr_nxt    = clr_r;
    addr_nxt   = addr_r;
    rd_ok_nxt  = rd_ok_r;
    res_nxt    = res_r;
    pool_we    = 1'b0;
    pool_waddr = '0;
    pool_wdata = '0;
    pool_re    = 1'b0;
    pool_raddr = '0;
    tab_we     = 1'b0;
    tab_waddr  = '0;
    tab_wdata  = '0;
    tab_re     = 1'b0;
    tab_raddr  = '0;
    in_stall   = 1'b1;
    res.valid  = 1'b0;
    res.data   = res_r;

    case (state_r)
      // Zero the pool byte by byte after reset
      ST_CLEAR: begin
        pool_we    = 1'b1;
        pool_waddr = clr_r;
        clr_nxt    = clr_r + AW'(1);
        if (clr_r == AW'(POOL_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          res_nxt = '0;
          case (in_data.func)
            FUNC_ALLOC: begin
              state_nxt = ST_DONE;
              if (count_r == CNTW'(MAX_ENTRIES) || left_w < need_w ||
                  fit_w > CW'(POOL_BYTES)) begin
                res_nxt.status = STATUS_NO_SPACE;
              end else begin
                tab_we      = 1'b1;
                tab_waddr   = count_r[IW-1:0];
                tab_wdata   = {off_w[PW-1:0], in_size_w[PW-1:0]};
                count_nxt   = count_r + CNTW'(1);
                left_nxt    = PW'(left_w - need_w);
                used_nxt    = fit_w[PW-1:0];
                res_nxt.block_start = off_w[SIZE_W-1:0];
              end
            end
            FUNC_FREE: begin
              addr_nxt  = in_data.address;
              idx_nxt   = '0;
              state_nxt = ST_SEARCH;
            end
            FUNC_WRITE: begin
              pool_we    = in_range;
              pool_waddr = in_addr_w[AW-1:0];
              pool_wdata = in_data.write_byte;
              state_nxt  = ST_DONE;
            end
            FUNC_READ: begin
              pool_re    = in_range;
              pool_raddr = in_addr_w[AW-1:0];
              rd_ok_nxt  = in_range;
              state_nxt  = ST_READ;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // Walk the table in order for the first matching offset
      ST_SEARCH: begin
        if (idx_r == count_r) begin
          res_nxt.status = STATUS_NOT_FOUND;
          state_nxt      = ST_DONE;
        end else begin
          tab_re    = 1'b1;
          tab_raddr = idx_r[IW-1:0];
          state_nxt = ST_MATCH;
        end
      end

      ST_MATCH: begin
        idx_nxt = idx_r + CNTW'(1);
        if (tab_off_w == CW'(addr_r)) begin
          gap_nxt   = tab_size;
          left_nxt  = PW'(left_w + tab_size_w + CW'(HEADER_BYTES));
          used_nxt  = used_r - tab_size;
          state_nxt = ST_NEXT;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end

      // Fetch the next later entry, or retire the freed one
      ST_NEXT: begin
        if (idx_r == count_r) begin
          count_nxt = count_r - CNTW'(1);
          state_nxt = ST_DONE;
        end else begin
          tab_re    = 1'b1;
          tab_raddr = idx_r[IW-1:0];
          state_nxt = ST_ENTRY;
        end
      end

      // Shift the entry down one slot with its new offset; move its bytes if it has any and they fit
      ST_ENTRY: begin
        tab_we    = 1'b1;
        tab_waddr = prev_idx[IW-1:0];
        tab_wdata = {new_off_w[PW-1:0], tab_size};
        if (tab_size != '0 && mv_end_w <= CW'(POOL_BYTES)) begin
          src_nxt   = tab_off;
          cnt_nxt   = tab_size;
          pend_nxt  = 1'b0;
          state_nxt = ST_MOVE;
        end else begin
          idx_nxt   = idx_r + CNTW'(1);
          state_nxt = ST_NEXT;
        end
      end

      // Copy bytes upward, highest first; a read feeds the write in the next cycle
      ST_MOVE: begin
        if (pend_r) begin
          pool_we    = 1'b1;
          pool_waddr = waddr_r;
          pool_wdata = pool_rdata;
        end
        if (cnt_r != '0) begin
          pool_re    = 1'b1;
          pool_raddr = rd_w[AW-1:0];
          waddr_nxt  = wr_w[AW-1:0];
          pend_nxt   = 1'b1;
          cnt_nxt    = cnt_r - PW'(1);
        end else begin
          pend_nxt  = 1'b0;
          idx_nxt   = idx_r + CNTW'(1);
          state_nxt = ST_NEXT;
        end
      end

      ST_READ: begin
        res_nxt.read_byte = rd_ok_r ? pool_rdata : '0;
        state_nxt         = ST_DONE;
      end

      // Hand the result over once the output register can take it
      ST_DONE: begin
        if (out_free) begin
          res.valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/compacting_pool_allocator_top.sv
// Top level of the compacting pool allocator: sequencer plus output register.
//
// Byte pool allocator with compaction. Blocks are placed downward from the top
// of a POOL_BYTES pool, each charged its size plus HEADER_BYTES; a free looks
// up the block table and moves every later block up to close the gap. The
// pool and the block table sit in single-write, single-read RAMs with a
// registered read, and one sequencer works on one request at a time. After
// reset the pool is zeroed one byte a cycle, and requests are stalled until
// the clear is done. Alloc and byte write finish straight from idle; a byte
// read also passes a read state for the pool RAM. A free takes the request,
// reads and compares table entries in order until one matches, then rewrites
// each later entry one slot down and copies its bytes, highest first; a free
// that matches nothing ends when the table is exhausted. The byte-by-byte move
// through the pool RAM sets the free time. The result waits in an output
// register, so the next request is taken while the previous result is still stalled.
`default_nettype none

module compacting_pool_allocator_top #(
  parameter int POOL_BYTES   = 1024,
  parameter int HEADER_BYTES = 8,
  parameter int MAX_ENTRIES  = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cpa_pkg::cpa_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cpa_pkg::cpa_out_t      out_data
);

  import cpa_pkg::*;

  cpa_res_t res;
  logic     out_valid_r;
  cpa_out_t out_data_r;
  logic     out_free;

  assign out_free = !out_valid_r || !out_stall;

  cpa_ctrl #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .out_free(out_free),
    .res     (res)
  );

  // Load a finished result; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A result is never issued over a stalled, unread one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (!out_valid_r || !out_stall))
    else $error("result issued while output register is full");

  // An issued result shows up at the output next cycle
  a_res_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> (out_valid && out_data == $past(res.data)))
    else $error("issued result not presented");

  // No request is taken while a result is being issued
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> in_stall)
    else $error("request accepted while issuing a result");

  // Only a successful alloc reports a block offset
  a_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.block_start != '0) |-> (out_data.status == STATUS_OK))
    else $error("block offset reported with a failure status");
`endif

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Directed and random test of the compacting pool allocator with a scoreboard.
module testbench;
  import cpa_pkg::*;

  localparam int POOL_BYTES   = 1024;
  localparam int HEADER_BYTES = 8;
  localparam int MAX_ENTRIES  = 128;
  localparam int HALF_PERIOD  = 10;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 10000000;
  localparam int IN_W         = $bits(cpa_in_t);

  typedef enum {RX_FREE_RUN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // Shadow pool, block table and the queue of predicted results
  class pool_scoreboard;
    logic [BYTE_W-1:0] pool_mem [POOL_BYTES];
    int blk_off [MAX_ENTRIES];
    int blk_size [MAX_ENTRIES];
    int blk_count;
    int free_bytes;
    int used_bytes;
    cpa_out_t result_q [$];
    int mismatches;
    int results_seen;
    int allocs_ok;
    int allocs_refused;
    int frees_ok;
    int frees_missed;
    int compactions;
    int peak_blocks;

    function new();
      foreach (pool_mem[i]) pool_mem[i] = '0;
      foreach (blk_off[i]) begin
        blk_off[i]  = 0;
        blk_size[i] = 0;
      end
      blk_count      = 0;
      free_bytes     = POOL_BYTES;
      used_bytes     = 0;
      mismatches     = 0;
      results_seen   = 0;
      allocs_ok      = 0;
      allocs_refused = 0;
      frees_ok       = 0;
      frees_missed   = 0;
      compactions    = 0;
      peak_blocks    = 0;
    endfunction

    // Predict the result of one accepted request and advance the shadow state
    function void note_request(cpa_in_t req);
      cpa_out_t res;
      int sz;
      int hit;
      int gap;
      int src;
      int n;
      res = '0;
      sz  = req.alloc_size;
      case (req.func)
        FUNC_ALLOC: begin
          if (blk_count >= MAX_ENTRIES || free_bytes < sz + HEADER_BYTES ||
              used_bytes + sz > POOL_BYTES) begin
            res.status = STATUS_NO_SPACE;
            allocs_refused++;
          end else begin
            blk_off[blk_count]  = POOL_BYTES - used_bytes - sz;
            blk_size[blk_count] = sz;
            res.block_start     = SIZE_W'(POOL_BYTES - used_bytes - sz);
            blk_count++;
            free_bytes -= sz + HEADER_BYTES;
            used_bytes += sz;
            allocs_ok++;
            if (blk_count > peak_blocks) peak_blocks = blk_count;
          end
        end
        FUNC_FREE: begin
          // First matching entry in table order wins
          hit = blk_count;
          for (int k = 0; k < blk_count; k++) begin
            if (hit == blk_count && blk_off[k] == int'(req.address)) hit = k;
          end
          if (hit == blk_count) begin
            res.status = STATUS_NOT_FOUND;
            frees_missed++;
          end else begin
            gap = blk_size[hit];
            free_bytes += gap + HEADER_BYTES;
            used_bytes -= gap;
            if (hit < blk_count - 1 && gap > 0) compactions++;
            // Move every later block up by the freed size, top byte first
            for (int j = hit + 1; j < blk_count; j++) begin
              src = blk_off[j];
              n   = blk_size[j];
              if (n > 0 && src + gap + n <= POOL_BYTES) begin
                for (int i = n - 1; i >= 0; i--)
                  pool_mem[src + gap + i] = pool_mem[src + i];
              end
              blk_off[j] = src + gap;
            end
            // Close the gap in the table
            for (int j = hit; j + 1 < blk_count; j++) begin
              blk_off[j]  = blk_off[j + 1];
              blk_size[j] = blk_size[j + 1];
            end
            blk_count--;
            frees_ok++;
          end
        end
        FUNC_WRITE: pool_mem[req.address] = req.write_byte;
        FUNC_READ:  res.read_byte = pool_mem[req.address];
        default: ;
      endcase
      result_q.push_back(res);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch on result %0d: %s is %0d, predicted %0d",
               results_seen, what, got, want);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest prediction
    task check_result(cpa_out_t got);
      cpa_out_t want;
      if (result_q.size() == 0) begin
        report_mismatch("unrequested result, status", int'(got.status), -1);
      end else begin
        want = result_q.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.block_start !== want.block_start)
          report_mismatch("block_start", int'(got.block_start), int'(want.block_start));
        if (got.read_byte !== want.read_byte)
          report_mismatch("read_byte", int'(got.read_byte), int'(want.read_byte));
      end
      results_seen++;
    endtask
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  cpa_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cpa_out_t out_data;

  pool_scoreboard sb;
  int cycle_count  = 0;
  int burst_left   = 0;
  int items_sent   = 0;
  bit hold_off_go   = 1'b0;
  bit hold_off_done = 1'b0;

  compacting_pool_allocator_top #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic cpa_in_t make_req(logic [FUNC_W-1:0] f, int size, int addr, int wb);
    cpa_in_t req;
    req.func       = f;
    req.alloc_size = SIZE_W'(size);
    req.address    = ADDR_W'(addr);
    req.write_byte = BYTE_W'(wb);
    return req;
  endfunction

  // Offer one request in bursts with random gaps; hold it until accepted
  task automatic offer(cpa_in_t req);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 10)) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk);
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    items_sent++;
  endtask

  // Mostly well-formed requests aimed at live blocks, plus raw noise
  function automatic cpa_in_t pick_request();
    logic [IN_W-1:0] raw;
    int roll;
    int lo;
    int size;
    int addr;
    roll = $urandom_range(0, 99);
    lo   = POOL_BYTES - sb.used_bytes;
    if (roll < 10) begin
      raw = IN_W'($urandom);
      return cpa_in_t'(raw);
    end
    if (roll < 38) begin
      roll = $urandom_range(0, 99);
      if (roll < 55)      size = $urandom_range(1, 48);
      else if (roll < 75) size = $urandom_range(49, 320);
      else if (roll < 85)
        size = (sb.free_bytes >= HEADER_BYTES) ? sb.free_bytes - HEADER_BYTES : 0;
      else if (roll < 92) size = (sb.used_bytes > 0) ? 0 : 1;
      else                size = $urandom_range(0, 2047);
      return make_req(FUNC_ALLOC, size, $urandom, $urandom);
    end
    if (roll < 63) begin
      if (sb.blk_count > 0 && $urandom_range(0, 9) != 0)
        addr = sb.blk_off[$urandom_range(0, sb.blk_count - 1)];
      else
        addr = $urandom;
      return make_req(FUNC_FREE, $urandom, addr, $urandom);
    end
    if (sb.used_bytes > 0 && $urandom_range(0, 4) != 0)
      addr = $urandom_range(lo, POOL_BYTES - 1);
    else
      addr = $urandom;
    if (roll < 85) return make_req(FUNC_WRITE, $urandom, addr, $urandom);
    return make_req(FUNC_READ, $urandom, addr, $urandom);
  endfunction

  task automatic run_directed();
    // Cleared pool, address extremes, all-ones unused fields
    offer(make_req(FUNC_READ, 0, 0, 0));
    offer(make_req(FUNC_READ, 2047, 1023, 255));
    offer(make_req(FUNC_WRITE, 0, 1023, 8'hFF));
    offer(make_req(FUNC_READ, 0, 1023, 0));
    offer(make_req(FUNC_WRITE, 0, 0, 8'hA5));
    offer(make_req(FUNC_READ, 0, 0, 0));
    // Free of an offset nobody holds
    offer(make_req(FUNC_FREE, 0, 512, 0));
    // Zero-size block sharing an offset with the block before it
    offer(make_req(FUNC_ALLOC, 16, 0, 0));
    offer(make_req(FUNC_ALLOC, 0, 0, 0));
    offer(make_req(FUNC_ALLOC, 32, 0, 0));
    offer(make_req(FUNC_WRITE, 0, 976, 8'h5A));
    offer(make_req(FUNC_WRITE, 0, 1007, 8'h3C));
    offer(make_req(FUNC_WRITE, 0, 1000, 8'h81));
    // Duplicate offset frees the first entry and compacts the rest
    offer(make_req(FUNC_FREE, 0, 1008, 0));
    offer(make_req(FUNC_READ, 0, 992, 0));
    offer(make_req(FUNC_READ, 0, 1007, 0));
    // No room: widest size, whole pool, then exact fit and one more
    offer(make_req(FUNC_ALLOC, 2047, 0, 0));
    offer(make_req(FUNC_ALLOC, POOL_BYTES, 0, 0));
    offer(make_req(FUNC_ALLOC, sb.free_bytes - HEADER_BYTES, 0, 0));
    offer(make_req(FUNC_ALLOC, 0, 0, 0));
    // Free the last block, then the one at offset 992 twice
    offer(make_req(FUNC_FREE, 0, sb.blk_off[sb.blk_count - 1], 0));
    offer(make_req(FUNC_FREE, 0, 992, 0));
    offer(make_req(FUNC_FREE, 0, 992, 0));
  endtask

  // Receiver: one long hold-off, otherwise randomly chosen stall modes
  initial begin : receiver
    rx_mode_t mode;
    int mode_left;
    int tick;
    int hold_left;
    mode      = RX_FREE_RUN;
    mode_left = 0;
    tick      = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_go && !hold_off_done) begin
        out_stall <= 1'b1;
        hold_left++;
        if (hold_left == HOLD_CYCLES) hold_off_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_FREE_RUN: out_stall <= 1'b0;
          RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (tick % 5 >= 3);
        endcase
      end
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, sb.result_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    hold_off_go = 1'b1;
    repeat (RANDOM_ITEMS) offer(pick_request());
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (sb.result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d blocks placed, %0d refused, %0d freed (%0d compacting),",
             items_sent, sb.allocs_ok, sb.allocs_refused, sb.frees_ok, sb.compactions);
    $display("%0d unmatched frees; %0d results checked, %0d mismatches, peak %0d blocks",
             sb.frees_missed, sb.results_seen, sb.mismatches, sb.peak_blocks);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/cpa_pkg.sv
hdl/cpa_ram.sv
hdl/cpa_ctrl.sv
hdl/compacting_pool_allocator_top.sv
tb/sv/testbench.sv
